// File: hdl/f32div_pkg.sv
package f32div_pkg;

    localparam int unsigned FRAC_BITS = 23;
    localparam int unsigned EXP_BITS  = 8;
    localparam int unsigned SIG_BITS  = FRAC_BITS + 1;
    // Remainder width: the doubled significand needs one extra bit.
    localparam int unsigned REM_BITS  = SIG_BITS + 1;
    localparam int unsigned DIV_STEPS = 25;
    localparam int unsigned STEPS_PER_STAGE_DEFAULT = 3;
    localparam logic [EXP_BITS-1:0] EXP_BIAS = 8'd127;

    // Per-item state that flows down the divider pipeline.
    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [SIG_BITS-1:0]  divisor;
        logic [DIV_STEPS-1:0] quo;
        logic [EXP_BITS-1:0]  expq;
    } div_state_t;

endpackage

// File: hdl/f32div_if.sv
interface f32div_if #(
    parameter int unsigned WIDTH = 32
) (
    input logic clk
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/f32div_stage.sv
// One pipeline stage: STEPS restoring division steps with a stalling register.
module f32div_stage #(
    parameter int unsigned STEPS = f32div_pkg::STEPS_PER_STAGE_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  f32div_pkg::div_state_t in_state,
    input  logic                   advance,
    output logic                   out_valid,
    output f32div_pkg::div_state_t out_state
);
    f32div_pkg::div_state_t state_next;
    f32div_pkg::div_state_t state_reg;
    logic                   valid_reg;

    // Restoring steps: subtract when the remainder covers the divisor.
    always_comb
    begin
        logic [f32div_pkg::REM_BITS-1:0] r;
        logic [f32div_pkg::REM_BITS-1:0] d;
        state_next = in_state;
        r = in_state.rem;
        d = {1'b0, in_state.divisor};
        for (int i = 0; i < STEPS; i++)
        begin
            state_next.quo = {state_next.quo[f32div_pkg::DIV_STEPS-2:0], (r >= d)};
            if (r >= d)
            begin
                r = r - d;
            end
            r = {r[f32div_pkg::REM_BITS-2:0], 1'b0};
        end
        state_next.rem = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
endmodule

// File: hdl/float32_restoring_divider.sv
// Pipeline: a front register, the division stage chain and an output register.
// Throughput: one request per cycle, except that the whole pipeline, including the
// division stage chain, holds while the output register is full and not taken.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module float32_restoring_divider #(
    parameter int unsigned STEPS_PER_STAGE = f32div_pkg::STEPS_PER_STAGE_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    f32div_if.sink   operands,
    f32div_if.source quotient
);
    localparam int unsigned N_STAGES = (f32div_pkg::DIV_STEPS + STEPS_PER_STAGE - 1)
                                       / STEPS_PER_STAGE;
    localparam int unsigned FB = f32div_pkg::FRAC_BITS;
    localparam int unsigned EB = f32div_pkg::EXP_BITS;
    localparam int unsigned SB = f32div_pkg::SIG_BITS;

    logic advance;
    logic out_valid_reg;
    logic [FB+EB-1:0] out_data_reg;

    // Whole pipeline moves unless the output register holds an untaken result.
    assign advance        = !out_valid_reg || quotient.ready;
    assign operands.ready = advance;

    // Front stage: exponent difference and significand pre-alignment.
    logic [EB-1:0] expa, expb;
    logic [SB-1:0] siga, sigb;
    f32div_pkg::div_state_t front_next;
    f32div_pkg::div_state_t front_reg;
    logic front_valid_reg;

    always_comb
    begin
        expa = operands.data[FB+EB-1:FB];
        expb = operands.data[32+FB+EB-1:32+FB];
        siga = {1'b1, operands.data[FB-1:0]};
        sigb = {1'b1, operands.data[32+FB-1:32]};
        front_next.divisor = sigb;
        front_next.quo     = '0;
        front_next.expq    = expa - expb + f32div_pkg::EXP_BIAS;
        if (siga < sigb)
        begin
            front_next.rem  = {siga, 1'b0};
            front_next.expq = expa - expb + f32div_pkg::EXP_BIAS - 8'd1;
        end
        else
        begin
            front_next.rem = {1'b0, siga};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= operands.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg <= front_next;
        end
    end

    // Division stage chain; the last stage may take fewer steps.
    logic                   stage_valid [N_STAGES+1];
    f32div_pkg::div_state_t stage_state [N_STAGES+1];

    assign stage_valid[0] = front_valid_reg;
    assign stage_state[0] = front_reg;

    for (genvar g = 0; g < N_STAGES; g++)
    begin : g_stage
        localparam int unsigned NSTEP =
            ((g + 1) * STEPS_PER_STAGE > f32div_pkg::DIV_STEPS)
            ? f32div_pkg::DIV_STEPS - g * STEPS_PER_STAGE : STEPS_PER_STAGE;
        f32div_stage #(.STEPS(NSTEP)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_state  (stage_state[g]),
            .advance   (advance),
            .out_valid (stage_valid[g+1]),
            .out_state (stage_state[g+1])
        );
    end

    // Rounding to nearest even and carry renormalization.
    f32div_pkg::div_state_t last;
    logic                   sticky;
    logic [SB:0]            q_rnd;
    logic [EB-1:0]          exp_fin;
    logic [FB-1:0]          frac_fin;

    always_comb
    begin
        last   = stage_state[N_STAGES];
        sticky = |last.rem;
        q_rnd  = {1'b0, last.quo[SB:1]}
                 + {{SB{1'b0}}, last.quo[0] & (sticky | last.quo[1])};
        if (q_rnd[SB])
        begin
            frac_fin = q_rnd[FB:1];
            exp_fin  = last.expq + 8'd1;
        end
        else
        begin
            frac_fin = q_rnd[FB-1:0];
            exp_fin  = last.expq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid[N_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {exp_fin, frac_fin};
        end
    end

    assign quotient.valid = out_valid_reg;
    assign quotient.data  = out_data_reg;
endmodule

// File: tb/sv/float32_restoring_divider_tb.sv
`timescale 1ns / 100ps

module float32_restoring_divider_tb;

    localparam int unsigned RANDOM_REQUESTS = 1150;
    localparam int unsigned DRAIN_CYCLES    = 40;

    logic clk;
    logic rst_n;

    // Operand channel carries {divisor, dividend}; quotient channel is 31 bits wide.
    f32div_if #(.WIDTH(64)) operands (.clk(clk));
    f32div_if #(.WIDTH(31)) quotient (.clk(clk));

    float32_restoring_divider u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands.sink),
        .quotient (quotient.source)
    );

    logic [63:0] pending_operands[$];
    logic [30:0] expected_quotients[$];
    int unsigned mismatch_count;
    int unsigned checked_count;
    int unsigned sent_count;
    bit          stimulus_done;
    logic        operands_taken;

    // Predicts the quotient word for one pair of operand words.
    function automatic logic [30:0] predict_quotient(logic [31:0] dividend, logic [31:0] divisor);
        logic [f32div_pkg::EXP_BITS-1:0]  expq;
        logic [f32div_pkg::REM_BITS:0]    rem;
        logic [f32div_pkg::SIG_BITS-1:0]  sig_b;
        logic [f32div_pkg::DIV_STEPS-1:0] quo;
        logic [f32div_pkg::SIG_BITS:0]    rounded;
        logic                             sticky;
        expq  = dividend[30:23] - divisor[30:23] + f32div_pkg::EXP_BIAS;
        rem   = {2'b0, 1'b1, dividend[22:0]};
        sig_b = {1'b1, divisor[22:0]};
        quo   = '0;
        if (rem < sig_b)
        begin
            rem  = rem << 1;
            expq = expq - 1'b1;
        end
        for (int k = 0; k < f32div_pkg::DIV_STEPS; k++)
        begin
            quo = quo << 1;
            if (rem >= sig_b)
            begin
                rem    = rem - sig_b;
                quo[0] = 1'b1;
            end
            rem = rem << 1;
        end
        sticky  = (rem != 0);
        rounded = {1'b0, quo[f32div_pkg::DIV_STEPS-1:1]}
                  + {{f32div_pkg::SIG_BITS{1'b0}}, quo[0] & (sticky | quo[1])};
        // A rounding carry renormalizes and bumps the exponent.
        if (rounded[f32div_pkg::SIG_BITS])
        begin
            rounded = rounded >> 1;
            expq    = expq + 1'b1;
        end
        return {expq, rounded[22:0]};
    endfunction

    function automatic int unsigned random_gap();
        if ($urandom_range(0, 99) < 70)
            return 0;
        else if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        // Sometimes pick an exponent near the wrap points.
        case ($urandom_range(0, 5))
            0: w[30:23] = 8'h00;
            1: w[30:23] = 8'hff;
            2: w[30:23] = 8'(127 + $urandom_range(0, 3) - 2);
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0)
            w[22:0] = ($urandom_range(0, 1) != 0) ? 23'h7fffff : 23'h0;
        return w;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset and stimulus generation.
    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        // Directed: extremes, wraps, rounding carry and specials.
        pending_operands.push_back({32'h3f800000, 32'h3f800000});
        pending_operands.push_back({32'h3f7fffff, 32'h3f800000});
        pending_operands.push_back({32'h3f800000, 32'h3f7fffff});
        pending_operands.push_back({32'h3fffffff, 32'h3f800001});
        pending_operands.push_back({32'h7f7fffff, 32'h00800000});
        pending_operands.push_back({32'h00800000, 32'h7f7fffff});
        pending_operands.push_back({32'h00000000, 32'h00000000});
        pending_operands.push_back({32'hffffffff, 32'hffffffff});
        pending_operands.push_back({32'h7f800000, 32'h3f800000});
        pending_operands.push_back({32'h7fc00000, 32'h40000000});
        pending_operands.push_back({32'h80000001, 32'h00000000});
        pending_operands.push_back({32'h40400000, 32'h3fc00000});
        pending_operands.push_back({32'h3f800000, 32'h40400000});
        pending_operands.push_back({32'h3f7fffff, 32'h3f7ffffe});
        pending_operands.push_back({32'h00000000, 32'hff800000});
        pending_operands.push_back({32'hff800000, 32'h007fffff});
        pending_operands.push_back({32'h3f800000, 32'h3fffffff});
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            a = random_word();
            b = random_word();
            pending_operands.push_back({b, a});
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        stimulus_done = 1'b1;
    end

    // Records whether the presented request was taken at the last rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            operands_taken <= 1'b0;
        else
            operands_taken <= operands.valid && operands.ready;
    end

    // Driver: presents queued requests with random gaps.
    int unsigned send_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operands.valid <= 1'b0;
            operands.data  <= '0;
            send_gap       = 0;
        end
        else if (!operands.valid || operands_taken)
        begin
            // The previous request (if any) was taken at the last rising edge.
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                operands.valid <= 1'b0;
            end
            else if (pending_operands.size() > 0)
            begin
                operands.valid <= 1'b1;
                operands.data  <= pending_operands.pop_front();
                send_gap = random_gap();
            end
            else
            begin
                operands.valid <= 1'b0;
            end
        end
    end

    // Result side stall pattern.
    int unsigned stall_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quotient.ready <= 1'b0;
            stall_left     = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            quotient.ready <= 1'b0;
        end
        else
        begin
            quotient.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = random_gap();
        end
    end

    // Monitor: predicts on accepted requests and checks accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (operands.valid && operands.ready)
            begin
                expected_quotients.push_back(
                    predict_quotient(operands.data[31:0], operands.data[63:32]));
                sent_count <= sent_count + 1;
            end
            if (quotient.valid && quotient.ready)
            begin
                checked_count <= checked_count + 1;
                if (expected_quotients.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected quotient %h", quotient.data);
                end
                else
                begin
                    logic [30:0] want;
                    want = expected_quotients.pop_front();
                    if (quotient.data !== want)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("ERROR: quotient_word expected %h actual %h",
                                     want, quotient.data);
                    end
                end
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        checked_count  = 0;
        sent_count     = 0;
    end

    // Wait for completion, then report.
    initial
    begin
        wait (stimulus_done);
        wait (pending_operands.size() == 0 && !operands.valid);
        wait (expected_quotients.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_quotients.size() != 0)
            mismatch_count = mismatch_count + expected_quotients.size();
        $display("Divided %0d operand pairs (directed edges plus random words);",
                 sent_count);
        $display("%0d quotients checked.", checked_count);
        if (mismatch_count == 0)
            $display("float32_restoring_divider_tb OK");
        else
            $display("float32_restoring_divider_tb NOT OK");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("Timeout with %0d quotients outstanding.", expected_quotients.size());
        $display("float32_restoring_divider_tb NOT OK");
        $finish;
    end

endmodule
